FILE: rtl/ofm_pkg.sv
// Shared types, constants and codes of the order-1 adaptive frequency model.
package ofm_pkg;

   // Default alphabet: 256 byte symbols plus end of stream
   localparam int SYMBOLS_DEF = 257;
   localparam int SYM_W_DEF   = $clog2(SYMBOLS_DEF);

   // Fixed field widths
   localparam int CMD_W  = 2;
   localparam int CNT_W  = 16;
   localparam int CUM_W  = CNT_W + 1;

   // Rescale threshold after reset
   localparam logic [CNT_W-1:0] THRESH_RESET = 16'd16383;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DECODE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   // Status codes
   localparam logic STAT_OK    = 1'b0;
   localparam logic STAT_RANGE = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_BUMP,
      ST_SCALE,
      ST_FINISH
   } state_type;

   // Control of the shared accumulate unit
   typedef struct packed {
      logic clear;
      logic add;
      logic halve;
   } accum_ctl_type;

endpackage

FILE: rtl/ofm_req_if.sv
// Request and response channel interfaces of the frequency model.
interface ofm_req_if
   import ofm_pkg::*;
#(
   parameter int SymW = SYM_W_DEF
) ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [SymW-1:0]  symbol;
   logic [CNT_W-1:0] target;

   modport source (output valid, command, symbol, target, input ready);
   modport sink   (input valid, command, symbol, target, output ready);
endinterface

interface ofm_rsp_if
   import ofm_pkg::*;
#(
   parameter int SymW = SYM_W_DEF
) ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] low;
   logic [CNT_W-1:0] high;
   logic [CNT_W-1:0] scale;
   logic [SymW-1:0]  found_symbol;
   logic             status;

   modport source (output valid, low, high, scale, found_symbol, status, input ready);
   modport sink   (input valid, low, high, scale, found_symbol, status, output ready);
endinterface

FILE: rtl/ofm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module ofm_ram
#(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/ofm_accum.sv
// Shared accumulate unit: running sum, target compare and count halving.
module ofm_accum
   import ofm_pkg::*;
(
   input  logic          clock,
   input  accum_ctl_type ctl,
   input  logic [CNT_W-1:0] word,
   input  logic [CNT_W-1:0] target,
   output logic [CUM_W-1:0] acc,
   output logic [CUM_W-1:0] sum_next,
   output logic             above,
   output logic [CNT_W-1:0] half
);

   logic [CUM_W-1:0] acc_ff;
   logic [CUM_W-1:0] acc_in;
   logic [CNT_W-1:0] operand;
   logic [CUM_W-1:0] word_inc;

   // Halve a count, rounding up
   assign word_inc = CUM_W'(word) + CUM_W'(1);
   assign half     = word_inc[CUM_W-1:1];

   // Add the selected operand and compare against the decode target
   assign operand  = ctl.halve ? half : word;
   assign sum_next = acc_ff + CUM_W'(operand);
   assign above    = sum_next > CUM_W'(target);

   // Clear, advance or hold the running sum
   always_comb begin
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.add) begin
         acc_in = sum_next;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/order1_adaptive_frequency_model_core.sv
// Order-1 adaptive frequency model for arithmetic coding, top level.
//
// One request is taken at a time. After reset the block sweeps the count memory once, one
// entry per cycle, setting every count to one and every context total to SYMBOLS; it
// accepts no request meanwhile, while threshold writes are taken at any time. A query, or a
// decode whose target is not below the context total, goes straight from setup to the
// response. Encoding symbol s, or decoding to symbol s, walks the context row through the
// single read port of the count memory, one count per cycle; when the incremented total
// reaches the threshold a rescale pass reads, halves and rewrites the whole row at one
// count per cycle. A finished response is held in an output register, so the next request
// can be accepted while it waits to be taken.
module order1_adaptive_frequency_model_core
   import ofm_pkg::*;
#(
   parameter int SYMBOLS = SYMBOLS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   ofm_req_if.sink          req_bus,
   ofm_rsp_if.source        rsp_bus,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata
);

   localparam int SYM_W    = $clog2(SYMBOLS);
   localparam int CT_DEPTH = SYMBOLS * SYMBOLS;
   localparam int CT_AW    = $clog2(CT_DEPTH);
   localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(SYMBOLS - 1);
   localparam logic [CT_AW-1:0] LAST_CLR = CT_AW'(CT_DEPTH - 1);

   // Control state
   state_type        state_ff,  state_in;
   logic [CT_AW-1:0] clr_ff,    clr_in;
   logic [SYM_W-1:0] prev_ff,   prev_in;
   logic [CNT_W-1:0] thr_ff,    thr_in;
   logic             pv_ff,     pv_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Request payload and working registers
   logic [CMD_W-1:0] cmd_ff,    cmd_in;
   logic [SYM_W-1:0] sym_ff,    sym_in;
   logic [CNT_W-1:0] tgt_ff,    tgt_in;
   logic [CT_AW-1:0] base_ff,   base_in;
   logic [CNT_W-1:0] total_ff,  total_in;
   logic [SYM_W-1:0] rd_idx_ff, rd_idx_in;
   logic [SYM_W-1:0] pidx_ff,   pidx_in;
   logic [CNT_W-1:0] lo_ff,     lo_in;
   logic [CNT_W-1:0] hi_ff,     hi_in;
   logic [SYM_W-1:0] found_ff,  found_in;
   logic [CNT_W-1:0] cnt_ff,    cnt_in;
   logic             status_ff, status_in;

   // Response register
   logic [CNT_W-1:0] rsp_lo_ff,     rsp_lo_in;
   logic [CNT_W-1:0] rsp_hi_ff,     rsp_hi_in;
   logic [CNT_W-1:0] rsp_scale_ff,  rsp_scale_in;
   logic [SYM_W-1:0] rsp_found_ff,  rsp_found_in;
   logic             rsp_status_ff, rsp_status_in;

   // Memory ports
   logic             ct_we;
   logic [CT_AW-1:0] ct_waddr;
   logic [CNT_W-1:0] ct_wdata;
   logic [CT_AW-1:0] ct_raddr;
   logic [CNT_W-1:0] ct_rdata;
   logic             tot_we;
   logic [SYM_W-1:0] tot_waddr;
   logic [CNT_W-1:0] tot_wdata;
   logic [CNT_W-1:0] tot_rdata;

   // Shared unit
   accum_ctl_type    acc_ctl;
   logic [CUM_W-1:0] acc;
   logic [CUM_W-1:0] sum_next;
   logic             above;
   logic [CNT_W-1:0] half;

   // Helpers
   logic             accept;
   logic [SYM_W-1:0] req_sym_sat;
   logic [CNT_W-1:0] bump_total;
   logic             stop;
   logic [SYM_W-1:0] widx;

   // Count table, one row per context
   ofm_ram #(
      .Width (CNT_W),
      .Depth (CT_DEPTH)
   ) u_count_ram (
      .clock (clock),
      .we    (ct_we),
      .waddr (ct_waddr),
      .wdata (ct_wdata),
      .raddr (ct_raddr),
      .rdata (ct_rdata)
   );

   // Context totals, read continuously at the current context
   ofm_ram #(
      .Width (CNT_W),
      .Depth (SYMBOLS)
   ) u_total_ram (
      .clock (clock),
      .we    (tot_we),
      .waddr (tot_waddr),
      .wdata (tot_wdata),
      .raddr (prev_ff),
      .rdata (tot_rdata)
   );

   ofm_accum u_accum (
      .clock    (clock),
      .ctl      (acc_ctl),
      .word     (ct_rdata),
      .target   (tgt_ff),
      .acc      (acc),
      .sum_next (sum_next),
      .above    (above),
      .half     (half)
   );

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   // Saturate out-of-range symbols to end of stream
   assign req_sym_sat = ((SYM_W + 1)'(req_bus.symbol) >= (SYM_W + 1)'(SYMBOLS)) ?
                        LAST_SYM : req_bus.symbol;

   assign bump_total = total_ff + CNT_W'(1);

   // Walk ends at the encoded symbol, or where the running sum passes the target or at the last symbol
   assign stop = (cmd_ff == CMD_ENCODE) ? (pidx_ff == sym_ff) : (above || pidx_ff == LAST_SYM);

   // Count memory addressing within the current row
   assign ct_raddr = base_ff + CT_AW'(rd_idx_ff);
   assign widx     = (state_ff == ST_BUMP) ? found_ff : pidx_ff;
   assign ct_waddr = (state_ff == ST_CLEAR) ? clr_ff : (base_ff + CT_AW'(widx));
   assign tot_waddr = (state_ff == ST_CLEAR) ? clr_ff[SYM_W-1:0] : prev_ff;

   // Sequencer: next state, datapath control and memory writes
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      prev_in       = prev_ff;
      thr_in        = csr_we ? csr_wdata : thr_ff;
      pv_in         = pv_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      cmd_in        = cmd_ff;
      sym_in        = sym_ff;
      tgt_in        = tgt_ff;
      base_in       = base_ff;
      total_in      = total_ff;
      rd_idx_in     = rd_idx_ff;
      pidx_in       = pidx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      found_in      = found_ff;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      rsp_lo_in     = rsp_lo_ff;
      rsp_hi_in     = rsp_hi_ff;
      rsp_scale_in  = rsp_scale_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      acc_ctl       = '0;
      ct_we         = 1'b0;
      ct_wdata      = cnt_ff + CNT_W'(1);
      tot_we        = 1'b0;
      tot_wdata     = bump_total;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep the memories to their reset contents
            ct_we     = 1'b1;
            ct_wdata  = CNT_W'(1);
            tot_we    = (CT_AW + 1)'(clr_ff) < (CT_AW + 1)'(SYMBOLS);
            tot_wdata = CNT_W'(SYMBOLS);
            clr_in    = clr_ff + CT_AW'(1);
            if (clr_ff == LAST_CLR) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            // Capture the request
            if (accept) begin
               cmd_in   = req_bus.command;
               sym_in   = req_sym_sat;
               tgt_in   = req_bus.target;
               state_in = ST_SETUP;
            end
         end

         ST_SETUP: begin
            // Locate the row, latch the total and pick the path
            base_in       = CT_AW'(prev_ff) * CT_AW'(SYMBOLS);
            total_in      = tot_rdata;
            acc_ctl.clear = 1'b1;
            rd_idx_in     = '0;
            pv_in         = 1'b0;
            lo_in         = '0;
            hi_in         = '0;
            found_in      = '0;
            status_in     = STAT_OK;
            unique case (cmd_ff)
               CMD_ENCODE: begin
                  state_in = ST_WALK;
               end
               CMD_DECODE: begin
                  if (tgt_ff >= tot_rdata) begin
                     status_in = STAT_RANGE;
                     state_in  = ST_FINISH;
                  end else begin
                     state_in  = ST_WALK;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end

         ST_WALK: begin
            // Issue one read per cycle; process the word read in the previous cycle
            rd_idx_in = (rd_idx_ff == LAST_SYM) ? rd_idx_ff : rd_idx_ff + SYM_W'(1);
            pidx_in   = rd_idx_ff;
            pv_in     = 1'b1;
            if (pv_ff) begin
               if (stop) begin
                  lo_in    = acc[CNT_W-1:0];
                  hi_in    = sum_next[CNT_W-1:0];
                  found_in = pidx_ff;
                  cnt_in   = ct_rdata;
                  state_in = ST_BUMP;
               end else begin
                  acc_ctl.add = 1'b1;
               end
            end
         end

         ST_BUMP: begin
            // Increment the coded symbol's count, then the total or rescale
            ct_we = 1'b1;
            if (bump_total >= thr_ff) begin
               acc_ctl.clear = 1'b1;
               rd_idx_in     = '0;
               pv_in         = 1'b0;
               state_in      = ST_SCALE;
            end else begin
               tot_we    = 1'b1;
               tot_wdata = bump_total;
               prev_in   = found_ff;
               state_in  = ST_FINISH;
            end
         end

         ST_SCALE: begin
            // Halve each count of the row and sum the new total
            rd_idx_in     = (rd_idx_ff == LAST_SYM) ? rd_idx_ff : rd_idx_ff + SYM_W'(1);
            pidx_in       = rd_idx_ff;
            pv_in         = 1'b1;
            acc_ctl.halve = 1'b1;
            if (pv_ff) begin
               ct_we       = 1'b1;
               ct_wdata    = half;
               acc_ctl.add = 1'b1;
               if (pidx_ff == LAST_SYM) begin
                  tot_we    = 1'b1;
                  tot_wdata = sum_next[CNT_W-1:0];
                  prev_in   = found_ff;
                  state_in  = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            // Load the response once the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_lo_in     = lo_ff;
               rsp_hi_in     = hi_ff;
               rsp_scale_in  = total_ff;
               rsp_found_in  = found_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         prev_ff      <= '0;
         thr_ff       <= THRESH_RESET;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         prev_ff      <= prev_in;
         thr_ff       <= thr_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      sym_ff        <= sym_in;
      tgt_ff        <= tgt_in;
      base_ff       <= base_in;
      total_ff      <= total_in;
      rd_idx_ff     <= rd_idx_in;
      pidx_ff       <= pidx_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      found_ff      <= found_in;
      cnt_ff        <= cnt_in;
      status_ff     <= status_in;
      rsp_lo_ff     <= rsp_lo_in;
      rsp_hi_ff     <= rsp_hi_in;
      rsp_scale_ff  <= rsp_scale_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.low          = rsp_lo_ff;
   assign rsp_bus.high         = rsp_hi_ff;
   assign rsp_bus.scale        = rsp_scale_ff;
   assign rsp_bus.found_symbol = rsp_found_ff;
   assign rsp_bus.status       = rsp_status_ff;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the order-1 adaptive frequency model core.
module testbench;
   import ofm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SYMBOLS = SYMBOLS_DEF;
   localparam int SYM_W = SYM_W_DEF;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   // The clearing pass after reset also runs without handshakes
   localparam int unsigned STALL_LIMIT = 300000;
   localparam int LONG_HOLD = 1500;

   typedef struct packed {
      logic [CNT_W-1:0] low;
      logic [CNT_W-1:0] high;
      logic [CNT_W-1:0] scale;
      logic [SYM_W-1:0] found;
      logic             status;
   } range_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [SYM_W-1:0] sym;
      logic [CNT_W-1:0] tgt;
      logic             typed;
      range_type        rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CNT_W-1:0] csr_wdata;

   ofm_req_if req_bus ();
   ofm_rsp_if rsp_bus ();

   order1_adaptive_frequency_model_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the model state
   logic [CNT_W-1:0] count_mem [SYMBOLS*SYMBOLS];
   logic [CNT_W-1:0] ctx_total [SYMBOLS];
   int unsigned      last_sym;
   int unsigned      threshold;

   range_type expected_ranges [$];
   int        mismatches = 0;
   int        idle_pct = 30;
   bit        hold_rsp_now = 1'b0;

   // Opening sequence; expected values typed in where they follow from reset
   dir_row_type directed_rows [22] = '{
      '{CMD_QUERY,  9'd0,   16'd0,     1'b1, '{16'd0,   16'd0,   16'd257, 9'd0,   STAT_OK}},
      '{CMD_SPARE,  9'd0,   16'd0,     1'b1, '{16'd0,   16'd0,   16'd257, 9'd0,   STAT_OK}},
      '{CMD_DECODE, 9'd0,   16'd257,   1'b1, '{16'd0,   16'd0,   16'd257, 9'd0,   STAT_RANGE}},
      '{CMD_DECODE, 9'd0,   16'hFFFF,  1'b1, '{16'd0,   16'd0,   16'd257, 9'd0,   STAT_RANGE}},
      '{CMD_ENCODE, 9'd0,   16'd0,     1'b1, '{16'd0,   16'd1,   16'd257, 9'd0,   STAT_OK}},
      '{CMD_ENCODE, 9'd256, 16'd0,     1'b1, '{16'd257, 16'd258, 16'd258, 9'd256, STAT_OK}},
      '{CMD_ENCODE, 9'h1FF, 16'hFFFF,  1'b1, '{16'd256, 16'd257, 16'd257, 9'd256, STAT_OK}},
      '{CMD_DECODE, 9'd0,   16'd0,     1'b1, '{16'd0,   16'd1,   16'd258, 9'd0,   STAT_OK}},
      '{CMD_QUERY,  9'h1FF, 16'hFFFF,  1'b1, '{16'd0,   16'd0,   16'd259, 9'd0,   STAT_OK}},
      '{CMD_DECODE, 9'd0,   16'd258,   1'b0, '0},
      '{CMD_DECODE, 9'h155, 16'h5555,  1'b0, '0},
      '{CMD_ENCODE, 9'h155, 16'h5555,  1'b0, '0},
      '{CMD_ENCODE, 9'h0AA, 16'hAAAA,  1'b0, '0},
      '{CMD_ENCODE, 9'd1,   16'd0,     1'b0, '0},
      '{CMD_ENCODE, 9'd255, 16'd0,     1'b0, '0},
      '{CMD_DECODE, 9'd0,   16'h00AA,  1'b0, '0},
      '{CMD_DECODE, 9'h0AA, 16'hAAAA,  1'b0, '0},
      '{CMD_SPARE,  9'h1FF, 16'hFFFF,  1'b0, '0},
      '{CMD_QUERY,  9'h1AA, 16'h1234,  1'b0, '0},
      '{CMD_ENCODE, 9'd128, 16'd0,     1'b0, '0},
      '{CMD_ENCODE, 9'd257, 16'd0,     1'b0, '0},
      '{CMD_DECODE, 9'd0,   16'd1,     1'b0, '0}
   };

   // Raise a count in the current context, rescale if needed, and move the context
   function automatic void bump_count(int unsigned sym);
      int unsigned base;
      int unsigned sum;
      int unsigned half;
      int unsigned i;
      base = last_sym * SYMBOLS;
      count_mem[base+sym] = count_mem[base+sym] + 16'd1;
      sum = (ctx_total[last_sym] + 1) & 16'hFFFF;
      if (sum >= threshold) begin
         sum = 0;
         for (i = 0; i < SYMBOLS; i++) begin
            half = (count_mem[base+i] + 1) >> 1;
            count_mem[base+i] = half[CNT_W-1:0];
            sum = (sum + half) & 16'hFFFF;
         end
      end
      ctx_total[last_sym] = sum[CNT_W-1:0];
      last_sym = sym;
   endfunction

   // Work out the coding range of one request and update the mirrored model
   function automatic range_type predict_coding_range(logic [CMD_W-1:0] cmd,
                                                      logic [SYM_W-1:0] sym,
                                                      logic [CNT_W-1:0] tgt);
      range_type   r;
      int unsigned base;
      int unsigned total;
      int unsigned cum;
      int unsigned pick;
      int unsigned i;
      r = '0;
      base = last_sym * SYMBOLS;
      total = 32'(ctx_total[last_sym]);
      r.scale = total[CNT_W-1:0];
      if (cmd == CMD_ENCODE) begin
         pick = (32'(sym) >= SYMBOLS) ? SYMBOLS - 1 : 32'(sym);
         cum = 0;
         for (i = 0; i < pick; i++)
            cum = cum + count_mem[base+i];
         r.low = cum[CNT_W-1:0];
         cum = cum + count_mem[base+pick];
         r.high = cum[CNT_W-1:0];
         r.found = pick[SYM_W-1:0];
         bump_count(pick);
      end else if (cmd == CMD_DECODE) begin
         if (tgt >= total) begin
            r.status = STAT_RANGE;
         end else begin
            cum = 0;
            pick = SYMBOLS;
            i = 0;
            while (pick == SYMBOLS && i < SYMBOLS) begin
               cum = cum + count_mem[base+i];
               if (cum > tgt)
                  pick = i;
               i++;
            end
            if (pick == SYMBOLS)
               pick = SYMBOLS - 1;
            r.high = cum[CNT_W-1:0];
            cum = cum - count_mem[base+pick];
            r.low = cum[CNT_W-1:0];
            r.found = pick[SYM_W-1:0];
            bump_count(pick);
         end
      end
      return r;
   endfunction

   // Offer one request, hold it until taken, then queue its expected range
   task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                                input logic [CNT_W-1:0] tgt, input logic typed,
                                input range_type typed_rsp);
      range_type predicted;
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.symbol  <= sym;
      req_bus.target  <= tgt;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predicted = predict_coding_range(cmd, sym, tgt);
      expected_ranges.push_back(typed ? typed_rsp : predicted);
   endtask

   // Drop valid for a random burst now and then
   task automatic sender_gap();
      if ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // Hold off new requests until every expected range has arrived
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_ranges.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_threshold(input logic [CNT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      threshold = 32'(value);
      csr_we <= 1'b0;
   endtask

   // Random requests: encodes mostly over a narrow alphabet so contexts fill up, decodes
   // mostly inside the context total, a few out of range, queries and the spare code
   task automatic run_random_phase(input int items, input int alpha_top, input int gap_pct);
      int               n;
      int               roll;
      logic [CMD_W-1:0] cmd;
      logic [SYM_W-1:0] sym;
      logic [CNT_W-1:0] tgt;
      idle_pct = gap_pct;
      for (n = 0; n < items; n++) begin
         roll = $urandom_range(0, 99);
         sym = SYM_W'($urandom_range(0, 511));
         tgt = CNT_W'($urandom_range(0, 65535));
         if (roll < 45) begin
            cmd = CMD_ENCODE;
            roll = $urandom_range(0, 99);
            if (roll < 85)
               sym = SYM_W'($urandom_range(0, alpha_top));
            else if (roll < 95)
               sym = SYM_W'($urandom_range(0, SYMBOLS - 1));
            else
               sym = SYM_W'($urandom_range(SYMBOLS, 511));
         end else if (roll < 85) begin
            cmd = CMD_DECODE;
            tgt = CNT_W'($urandom_range(0, ctx_total[last_sym] - 1));
         end else if (roll < 92) begin
            cmd = CMD_DECODE;
            tgt = CNT_W'($urandom_range(ctx_total[last_sym], 65535));
         end else begin
            cmd = roll[0] ? CMD_QUERY : CMD_SPARE;
         end
         offer_request(cmd, sym, tgt, 1'b0, '0);
         sender_gap();
      end
      drain_results();
   endtask

   // Clear the mirrored model
   initial begin : model_reset
      int i;
      for (i = 0; i < SYMBOLS * SYMBOLS; i++)
         count_mem[i] = 16'd1;
      for (i = 0; i < SYMBOLS; i++)
         ctx_total[i] = CNT_W'(SYMBOLS);
      last_sym = 0;
      threshold = 32'(THRESH_RESET);
   end

   // Take responses with random stalls and compare against the oldest expectation
   initial begin : rsp_side
      int        stall_left;
      range_type want;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_ranges.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: low %0d high %0d scale %0d sym %0d status %0d",
                           rsp_bus.low, rsp_bus.high, rsp_bus.scale, rsp_bus.found_symbol,
                           rsp_bus.status);
            end else begin
               want = expected_ranges.pop_front();
               if (rsp_bus.low !== want.low || rsp_bus.high !== want.high ||
                   rsp_bus.scale !== want.scale || rsp_bus.found_symbol !== want.found ||
                   rsp_bus.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch (exp/act): low %0d/%0d high %0d/%0d",
                              want.low, rsp_bus.low, want.high, rsp_bus.high,
                              " scale %0d/%0d sym %0d/%0d status %0d/%0d",
                              want.scale, rsp_bus.scale, want.found, rsp_bus.found_symbol,
                              want.status, rsp_bus.status);
               end
            end
         end
         // Long hold-off: let the core fill up and stall its request side
         if (hold_rsp_now) begin
            hold_rsp_now = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(1, 19) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // End the run when nothing moves for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int k;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_QUERY;
      req_bus.symbol = '0;
      req_bus.target = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (k = 0; k < $size(directed_rows); k++) begin
         offer_request(directed_rows[k].cmd, directed_rows[k].sym, directed_rows[k].tgt,
                       directed_rows[k].typed, directed_rows[k].rsp);
         sender_gap();
      end
      drain_results();

      // Lowest threshold: every update rescales
      set_threshold(16'd258);
      run_random_phase(150, 7, 30);
      // Low threshold with frequent rescales, and a long response hold-off
      set_threshold(16'd300);
      hold_rsp_now = 1'b1;
      run_random_phase(250, 3, 30);
      // Highest threshold, full alphabet, no idling
      set_threshold(16'hFFFF);
      run_random_phase(150, 256, 0);
      set_threshold(THRESH_RESET);
      run_random_phase(250, 15, 30);
      // Last stretch runs at full rate
      set_threshold(CNT_W'($urandom_range(258, 2000)));
      run_random_phase(200, 31, 0);

      repeat (2 * SYMBOLS + 16) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
